// ===== hw/rtl/c1dr_pkg.sv =====
// ----------------------------------------------------------------------------
// c1dr_pkg: shared types and codes for the conv1d relu layer
// Command codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package c1dr_pkg;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // one classified command handed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  addr;
    logic [15:0] value;
    logic        frame_end;
  } op_t;

endpackage

// ===== hw/rtl/conv1d_relu_layer_core.sv =====
// ----------------------------------------------------------------------------
// conv1d_relu_layer_core: conv1d layer with bias and relu
// Front classifier, two-entry queue and mac back end.
//
//  channel  | handshake         | payload
//  input    | push / full       | cmd, addr, value
//  result   | empty / pop       | filter_index, window_index, activation, last
//
// Writes and non-final samples leave the back end idle, ready for the next command.
// Each activation is summed on the single mac unit, one tap and axis per step.
// The back end accepts no command while a frame's results are pending.
// Reset is synchronous; stores are undefined until written.
// ----------------------------------------------------------------------------
module conv1d_relu_layer_core #(
  parameter int INPUT_LEN  = 32,
  parameter int AXES       = 6,
  parameter int KERNEL_LEN = 5,
  parameter int FILTERS    = 8,
  parameter int STRIDE     = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  addr,
  input  logic [15:0] value,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  filter_index,
  output logic [5:0]  window_index,
  output logic [14:0] activation,
  output logic        last
);
  import c1dr_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  op_t  f_op, b_op;

  c1dr_front #(.S_DEPTH(INPUT_LEN * AXES)) u_front (
    .clk, .rst, .push, .full, .cmd, .addr, .value,
    .op_valid(f_valid), .op(f_op), .op_ready(f_ready)
  );

  c1dr_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_op(f_op),
    .out_valid(b_valid), .out_ready(b_ready), .out_op(b_op)
  );

  c1dr_back #(
    .INPUT_LEN(INPUT_LEN), .AXES(AXES), .KERNEL_LEN(KERNEL_LEN),
    .FILTERS(FILTERS), .STRIDE(STRIDE)
  ) u_back (
    .clk, .rst, .op_valid(b_valid), .op_ready(b_ready), .op(b_op),
    .empty, .pop, .filter_index, .window_index, .activation, .last
  );

endmodule

// ===== hw/rtl/c1dr_front.sv =====
// ----------------------------------------------------------------------------
// c1dr_front: input classifier
// Accepts commands, tracks the sample count and tags the frame's last sample.
// ----------------------------------------------------------------------------
module c1dr_front #(
  parameter int S_DEPTH = 192
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     cmd,
  input  logic [7:0]     addr,
  input  logic [15:0]    value,
  output logic           op_valid,
  output c1dr_pkg::op_t  op,
  input  logic           op_ready
);
  import c1dr_pkg::*;

  localparam int CW = $clog2(S_DEPTH + 1);

  logic [CW-1:0] sample_count;
  logic          take;

  assign full     = !op_ready;
  assign take     = push && op_ready;
  assign op_valid = push;

  // classification
  always_comb begin
    op.cmd       = cmd_t'(cmd);
    op.addr      = addr;
    op.value     = value;
    op.frame_end = (cmd_t'(cmd) == CMD_SAMPLE) &&
                   (sample_count == CW'(S_DEPTH - 1));
  end

  // frame sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (take && cmd_t'(cmd) == CMD_SAMPLE) begin
      if (sample_count == CW'(S_DEPTH - 1)) sample_count <= '0;
      else sample_count <= sample_count + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/c1dr_queue.sv =====
// ----------------------------------------------------------------------------
// c1dr_queue: short command queue
// Two-entry fifo that decouples the classifier from the compute engine.
// ----------------------------------------------------------------------------
module c1dr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  c1dr_pkg::op_t  in_op,
  output logic           out_valid,
  input  logic           out_ready,
  output c1dr_pkg::op_t  out_op
);
  import c1dr_pkg::*;

  op_t        mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;
  assign out_op    = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_op;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== hw/rtl/c1dr_back.sv =====
// ----------------------------------------------------------------------------
// c1dr_back: storage and mac engine
// Holds weights, biases, samples; runs one mac per cycle, stalls until each pop.
// ----------------------------------------------------------------------------
module c1dr_back #(
  parameter int INPUT_LEN  = 32,
  parameter int AXES       = 6,
  parameter int KERNEL_LEN = 5,
  parameter int FILTERS    = 8,
  parameter int STRIDE     = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           op_valid,
  output logic           op_ready,
  input  c1dr_pkg::op_t  op,
  output logic           empty,
  input  logic           pop,
  output logic [3:0]     filter_index,
  output logic [5:0]     window_index,
  output logic [14:0]    activation,
  output logic           last
);
  import c1dr_pkg::*;

  localparam int W_DEPTH = KERNEL_LEN * AXES * FILTERS;
  localparam int S_DEPTH = INPUT_LEN * AXES;
  localparam int WINS    = (KERNEL_LEN > INPUT_LEN) ? 0 :
                           (INPUT_LEN - KERNEL_LEN) / STRIDE + 1;
  localparam int NRES    = (FILTERS * WINS > 64) ? 64 : FILTERS * WINS;
  localparam int WAW     = $clog2(W_DEPTH);
  localparam int SAW     = $clog2(S_DEPTH);
  localparam int FW      = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int WW      = (WINS > 1) ? $clog2(WINS) : 1;
  localparam int TW      = (KERNEL_LEN > 1) ? $clog2(KERNEL_LEN) : 1;
  localparam int AW      = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int RW      = 7;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;

  logic [15:0] weight_mem [W_DEPTH];
  logic [15:0] sample_mem [S_DEPTH];
  logic [15:0] bias_reg   [FILTERS];
  logic [SAW-1:0] wr_ptr;

  logic [FW-1:0] f;
  logic [WW-1:0] w;
  logic [TW-1:0] t;
  logic [AW-1:0] a;
  logic [RW-1:0] nres;
  logic          step_last;
  logic          rd_vld, prod_vld;
  logic [15:0]   s_q, w_q;
  logic signed [31:0] prod;
  logic signed [39:0] acc;
  logic          out_full;

  logic [SAW-1:0] s_idx;
  logic [WAW-1:0] w_idx;

  assign op_ready = (state == ST_IDLE);
  assign empty    = !out_full;

  // addresses for the current tap and axis
  always_comb begin
    s_idx = SAW'((32'(t) + STRIDE * 32'(w)) * AXES + 32'(a));
    w_idx = WAW'(32'(t) * AXES * FILTERS + 32'(a) * FILTERS + 32'(f));
  end
  assign step_last = (32'(t) == KERNEL_LEN - 1) && (32'(a) == AXES - 1);

  // write port and read port of the stores
  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      if (op.cmd == CMD_WEIGHT && 32'(op.addr) < W_DEPTH)
        weight_mem[op.addr[WAW-1:0]] <= op.value;
      if (op.cmd == CMD_BIAS && 32'(op.addr) < FILTERS)
        bias_reg[op.addr[FW-1:0]] <= op.value;
      if (op.cmd == CMD_SAMPLE)
        sample_mem[wr_ptr] <= op.value;
    end
    s_q <= sample_mem[s_idx];
    w_q <= weight_mem[w_idx];
  end

  // sample write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
    end else if (op_valid && op_ready && op.cmd == CMD_SAMPLE) begin
      wr_ptr <= op.frame_end ? '0 : wr_ptr + 1'b1;
    end
  end

  // product register then accumulate; bias loads on the first step of a window
  always_ff @(posedge clk) begin
    prod <= $signed(s_q) * $signed(w_q);
    if (state == ST_MAC && t == '0 && a == '0)
      acc <= 40'(signed'(bias_reg[f])) <<< 8;
    else if (prod_vld)
      acc <= acc + 40'(prod);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      f <= '0; w <= '0; t <= '0; a <= '0;
      nres     <= '0;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
      out_full <= 1'b0;
    end else begin
      prod_vld <= rd_vld;
      unique case (state)
        ST_IDLE: begin
          f <= '0; w <= '0; t <= '0; a <= '0; nres <= '0;
          rd_vld <= 1'b0;
          if (op_valid && op.cmd == CMD_SAMPLE && op.frame_end && NRES > 0) begin
            state  <= ST_MAC;
          end
        end
        ST_MAC: begin
          rd_vld <= 1'b1;
          if (step_last) begin
            t <= '0; a <= '0;
            state <= ST_FIN;
          end else if (32'(a) == AXES - 1) begin
            a <= '0; t <= t + 1'b1;
          end else begin
            a <= a + 1'b1;
          end
        end
        ST_FIN: begin
          rd_vld <= 1'b0;
          if (!rd_vld && !prod_vld) begin
            out_full <= 1'b1;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (pop) begin
            out_full <= 1'b0;
            nres     <= nres + 1'b1;
            if (32'(nres) == NRES - 1) begin
              state <= ST_IDLE;
            end else begin
              if (32'(w) == WINS - 1) begin
                w <= '0; f <= f + 1'b1;
              end else begin
                w <= w + 1'b1;
              end
              state <= ST_MAC;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // relu and saturation
  always_comb begin
    filter_index = 4'(f);
    window_index = 6'(w);
    last         = (32'(nres) == NRES - 1);
    if (acc <= 0) activation = '0;
    else if (acc[39:23] != '0) activation = 15'h7fff;
    else activation = acc[22:8];
  end

  // checks
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_full |-> state == ST_OUT) else $error("result shown outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !op_ready) else $error("accept while busy");
  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && pop) |=> !out_full) else $error("result not cleared");

endmodule

// ===== tb/sv/conv1d_relu_layer_core_tb.sv =====
// ----------------------------------------------------------------------------
// conv1d_relu_layer_core_tb: self-checking bench for the conv1d relu layer
// Loads weights and biases, streams a sample frame and checks every
// activation against a local predictor of the layer, under varied idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv1d_relu_layer_core_tb;
  import c1dr_pkg::*;

  localparam int INPUT_LEN  = 32;
  localparam int AXES       = 6;
  localparam int KERNEL_LEN = 5;
  localparam int FILTERS    = 8;
  localparam int STRIDE     = 4;
  localparam int W_DEPTH    = KERNEL_LEN * AXES * FILTERS;
  localparam int S_DEPTH    = INPUT_LEN * AXES;
  localparam int WINDOWS    = (INPUT_LEN - KERNEL_LEN) / STRIDE + 1;
  localparam int MAX_ACTS   = 64;

  typedef struct packed {
    logic [3:0]  filt;
    logic [5:0]  win;
    logic [14:0] act;
    logic        lst;
  } act_t;

  typedef struct {
    cmd_t        op;
    logic [7:0]  adr;
    logic [15:0] val;
  } stim_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  cmd;
  logic [7:0]  addr;
  logic [15:0] value;
  logic        empty;
  logic        pop;
  logic [3:0]  filter_index;
  logic [5:0]  window_index;
  logic [14:0] activation;
  logic        last;

  // predictor state
  logic signed [15:0] kern_mem [W_DEPTH];
  logic signed [15:0] bias_mem [FILTERS];
  logic signed [15:0] frame_mem [S_DEPTH];
  int                 frame_fill;

  act_t expected_acts [$];
  int   errors;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   frames_done;
  int   acts_checked;
  int   items_sent;

  conv1d_relu_layer_core #(
    .INPUT_LEN (INPUT_LEN),
    .AXES      (AXES),
    .KERNEL_LEN(KERNEL_LEN),
    .FILTERS   (FILTERS),
    .STRIDE    (STRIDE)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .addr        (addr),
    .value       (value),
    .empty       (empty),
    .pop         (pop),
    .filter_index(filter_index),
    .window_index(window_index),
    .activation  (activation),
    .last        (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // overall time limit
  initial begin
    #4000000;
    $display("timeout at %0t", $time);
    $display("Verification failed");
    $finish;
  end

  // layer predictor: update stores, queue activations on frame end
  task automatic predict_layer(input stim_t s);
    logic signed [39:0] acc;
    logic [39:0]        shifted;
    act_t               r;
    int                 n;
    n = 0;
    case (s.op)
      CMD_WEIGHT: if (s.adr < W_DEPTH) kern_mem[s.adr] = s.val;
      CMD_BIAS:   if (s.adr < FILTERS) bias_mem[s.adr] = s.val;
      CMD_SAMPLE: begin
        frame_mem[frame_fill] = s.val;
        frame_fill++;
        if (frame_fill == S_DEPTH) begin
          frame_fill = 0;
          frames_done++;
          for (int f = 0; f < FILTERS; f++) begin
            for (int w = 0; w < WINDOWS; w++) begin
              if (n < MAX_ACTS) begin
                acc = 40'(bias_mem[f]) <<< 8;
                for (int t = 0; t < KERNEL_LEN; t++) begin
                  for (int a = 0; a < AXES; a++) begin
                    acc += 40'(frame_mem[(t + STRIDE * w) * AXES + a]) *
                           40'(kern_mem[t * AXES * FILTERS + a * FILTERS + f]);
                  end
                end
                r.filt = 4'(f);
                r.win  = 6'(w);
                r.lst  = 1'b0;
                if (acc <= 0) r.act = '0;
                else begin
                  shifted = acc >>> 8;
                  r.act = (shifted > 40'd32767) ? 15'h7fff : shifted[14:0];
                end
                expected_acts.push_back(r);
                n++;
              end
            end
          end
          if (n > 0) expected_acts[$].lst = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // idling mix for one phase
  task automatic set_phase(input int ph);
    case (ph)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  // one input transfer with random sender idling
  task automatic send_item(input stim_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push  <= 1'b1;
    cmd   <= s.op;
    addr  <= s.adr;
    value <= s.val;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_layer(s);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic stim_t mk(input cmd_t c, input int a, input int v);
    stim_t s;
    s.op  = c;
    s.adr = 8'(a);
    s.val = 16'(v);
    return s;
  endfunction

  // write every weight and bias; the first two filters get full-scale values
  task automatic load_params;
    int mag;
    for (int i = 0; i < W_DEPTH; i++) begin
      mag = (i % FILTERS < 2) ? 32767 : 256;
      send_item(mk(CMD_WEIGHT, i, $urandom_range(2 * mag) - mag));
    end
    for (int f = 0; f < FILTERS; f++) begin
      mag = (f < 2) ? 32767 : 256;
      send_item(mk(CMD_BIAS, f, $urandom_range(2 * mag) - mag));
    end
  endtask

  // a full frame with interleaved noise commands, walked through the phases
  task automatic send_frame;
    int v;
    for (int i = 0; i < S_DEPTH; i++) begin
      if (i % (S_DEPTH / 4) == 0) set_phase(i / (S_DEPTH / 4));
      if ($urandom_range(99) < 10) v = $urandom_range(1) ? 16'h7fff : 16'h8000;
      else v = $urandom_range(1024) - 512;
      send_item(mk(CMD_SAMPLE, 0, v));
      if ($urandom_range(99) < 3)
        send_item(mk(CMD_NONE, $urandom_range(255), $urandom_range(65535)));
      if ($urandom_range(99) < 2)
        send_item(mk(CMD_WEIGHT, W_DEPTH + $urandom_range(255 - W_DEPTH),
                     $urandom_range(65535)));
      if ($urandom_range(99) < 2)
        send_item(mk(CMD_BIAS, FILTERS + $urandom_range(255 - FILTERS),
                     $urandom_range(65535)));
    end
  endtask

  // wait for the results, stepping the receiver through the phases
  task automatic drain;
    int guard;
    int base;
    push <= 1'b0;
    guard = 0;
    base = acts_checked;
    while (expected_acts.size() != 0 && guard < 200000) begin
      set_phase((acts_checked - base) * 4 / (FILTERS * WINDOWS));
      @(posedge clk);
      guard++;
    end
    set_phase(0);
    repeat (KERNEL_LEN * AXES + 20) @(posedge clk);
  endtask

  // result checker and random receiver stall
  always @(posedge clk) begin
    act_t want;
    if (!rst && pop && !empty) begin
      if (expected_acts.size() == 0) begin
        $display("%0t unexpected transfer: got f=%0d w=%0d act=%0d last=%0d", $time,
                 filter_index, window_index, activation, last);
        errors++;
      end else begin
        want = expected_acts.pop_front();
        acts_checked++;
        if (want.filt !== filter_index || want.win !== window_index ||
            want.act !== activation || want.lst !== last) begin
          $display("%0t mismatch: exp f=%0d w=%0d act=%0d last=%0d, got f=%0d w=%0d act=%0d last=%0d",
                   $time, want.filt, want.win, want.act, want.lst,
                   filter_index, window_index, activation, last);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // directed table: extremes, each command, ignored addresses
  stim_t directed [20];

  initial begin
    errors = 0;
    frame_fill = 0;
    frames_done = 0;
    acts_checked = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push = 1'b0;
    cmd = CMD_NONE;
    addr = '0;
    value = '0;
    rst = 1'b1;
    for (int i = 0; i < W_DEPTH; i++) kern_mem[i] = '0;
    for (int i = 0; i < FILTERS; i++) bias_mem[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed[0]  = mk(CMD_WEIGHT, 0, 16'h7fff);
    directed[1]  = mk(CMD_WEIGHT, W_DEPTH - 1, 16'h8000);
    directed[2]  = mk(CMD_WEIGHT, W_DEPTH, 16'h1234);
    directed[3]  = mk(CMD_WEIGHT, 255, 16'hffff);
    directed[4]  = mk(CMD_BIAS, 0, 16'h7fff);
    directed[5]  = mk(CMD_BIAS, FILTERS - 1, 16'h8000);
    directed[6]  = mk(CMD_BIAS, FILTERS, 16'h5555);
    directed[7]  = mk(CMD_BIAS, 255, 16'haaaa);
    directed[8]  = mk(CMD_NONE, 0, 0);
    directed[9]  = mk(CMD_NONE, 255, 16'hffff);
    directed[10] = mk(CMD_NONE, 8'haa, 16'h5555);
    directed[11] = mk(CMD_WEIGHT, 1, 16'h0100);
    directed[12] = mk(CMD_BIAS, 1, 16'h0001);
    directed[13] = mk(CMD_WEIGHT, 2, 0);
    directed[14] = mk(CMD_BIAS, 2, 0);
    directed[15] = mk(CMD_WEIGHT, 8'h55, 16'haaaa);
    directed[16] = mk(CMD_WEIGHT, 8'haa, 16'h5555);
    directed[17] = mk(CMD_BIAS, 3, 16'hff00);
    directed[18] = mk(CMD_WEIGHT, 3, 16'h0001);
    directed[19] = mk(CMD_NONE, 1, 1);
    set_phase(0);
    foreach (directed[i]) send_item(directed[i]);

    // full parameter set, then one frame with saturating and clamped filters
    load_params();
    send_frame();
    drain();

    $display("covered %0d input transfers, %0d frames, %0d activations checked",
             items_sent, frames_done, acts_checked);
    $display("sender and receiver idling stepped through four phases");
    if (errors == 0 && expected_acts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors, %0d activations left over", errors, expected_acts.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/c1dr_pkg.sv
hw/rtl/c1dr_front.sv
hw/rtl/c1dr_queue.sv
hw/rtl/c1dr_back.sv
hw/rtl/conv1d_relu_layer_core.sv
tb/sv/conv1d_relu_layer_core_tb.sv
